// ===== hw/rtl/hcbd_pkg.sv =====
package hcbd_pkg;

    localparam int MAX_LINE_CHARS = 8;
    localparam int LINE_W         = $clog2(MAX_LINE_CHARS + 1);
    localparam int SIZE_W         = 28;
    localparam int HEX_W          = 4;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef enum logic [5:0] {
        PH_LINE    = 6'b000001,
        PH_BREAK   = 6'b000010,
        PH_PAYLOAD = 6'b000100,
        PH_SKIP    = 6'b001000,
        PH_FINAL   = 6'b010000,
        PH_STOP    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       begin_body;
    } t_in_item;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       chunk_last;
        logic       body_done;
        logic       framing_error;
        logic       bad_line_break;
    } t_out_item;

    typedef struct packed {
        t_phase              phase;
        logic [LINE_W-1:0]   line_chars;
        logic [SIZE_W-1:0]   size_accum;
        logic                digits_stopped;
        logic [SIZE_W-1:0]   bytes_left;
        logic                skip_left;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:          PH_LINE,
        line_chars:     '0,
        size_accum:     '0,
        digits_stopped: 1'b0,
        bytes_left:     '0,
        skip_left:      1'b0
    };

    // bit HEX_W flags a hex digit, low bits give its value
    function automatic logic [HEX_W:0] hex_decode(input logic [7:0] c);
        logic [HEX_W:0] r;
        r = '0;
        case (c) inside
            [8'h30:8'h39]: r = {1'b1, 4'(c - 8'h30)};
            [8'h61:8'h66]: r = {1'b1, 4'(c - 8'h57)};
            [8'h41:8'h46]: r = {1'b1, 4'(c - 8'h37)};
            default:       r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/hcbd_step.sv =====
module hcbd_step (
    input  hcbd_pkg::t_state    i_state,
    input  hcbd_pkg::t_in_item  i_item,
    output hcbd_pkg::t_state    o_state,
    output hcbd_pkg::t_out_item o_result
);
    import hcbd_pkg::*;

    t_state         s;
    t_state         n;
    t_out_item      res;
    logic [HEX_W:0] hex;

    assign hex = hex_decode(i_item.in_byte);

    always_comb begin
        s   = i_item.begin_body ? STATE_RESET : i_state;
        n   = s;
        res = '0;
        case (s.phase)
            PH_LINE: begin
                if (i_item.in_byte == CHAR_CR) begin
                    n.phase = PH_BREAK;
                end else begin
                    if (s.line_chars < LINE_W'(MAX_LINE_CHARS)) begin
                        n.line_chars = s.line_chars + LINE_W'(1);
                    end
                    if (!s.digits_stopped) begin
                        if (!hex[HEX_W]) begin
                            n.digits_stopped = 1'b1;
                        end else if (s.size_accum[SIZE_W-1 -: HEX_W] != '0) begin
                            n.size_accum = '1;
                        end else begin
                            n.size_accum = {s.size_accum[SIZE_W-HEX_W-1:0], hex[HEX_W-1:0]};
                        end
                    end
                end
            end
            PH_BREAK: begin
                res.bad_line_break = (i_item.in_byte != CHAR_LF);
                if (s.line_chars == '0 || s.line_chars >= LINE_W'(MAX_LINE_CHARS)) begin
                    res.framing_error = 1'b1;
                    n.phase           = PH_STOP;
                end else if (s.size_accum != '0) begin
                    n.bytes_left = s.size_accum;
                    n.phase      = PH_PAYLOAD;
                end else begin
                    n.skip_left = 1'b1;
                    n.phase     = PH_FINAL;
                end
            end
            PH_PAYLOAD: begin
                res.payload_valid = 1'b1;
                res.payload_byte  = i_item.in_byte;
                if (s.bytes_left <= SIZE_W'(1)) begin
                    n.bytes_left   = '0;
                    res.chunk_last = 1'b1;
                    n.skip_left    = 1'b1;
                    n.phase        = PH_SKIP;
                end else begin
                    n.bytes_left = s.bytes_left - SIZE_W'(1);
                end
            end
            PH_SKIP: begin
                if (s.skip_left) begin
                    n.skip_left = 1'b0;
                end else begin
                    n.phase          = PH_LINE;
                    n.line_chars     = '0;
                    n.size_accum     = '0;
                    n.digits_stopped = 1'b0;
                end
            end
            PH_FINAL: begin
                if (s.skip_left) begin
                    n.skip_left = 1'b0;
                end else begin
                    res.body_done = 1'b1;
                    n.phase       = PH_STOP;
                end
            end
            default: begin
                n.phase = PH_STOP;
            end
        endcase
    end

    assign o_state  = n;
    assign o_result = res;

endmodule

// ===== hw/rtl/http_chunked_body_decoder.sv =====
// Results are registered: input register, then the combinational decode step, then result register.
// Throughput: one byte per cycle unless the output stalls; decode step is combinational.
// Back-pressure on the output stalls the input register only when both stages are full.
// Reset (i_rst_n low, synchronous): both stages empty, decoder waits for a size line.
module http_chunked_body_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hcbd_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hcbd_pkg::t_out_item o_out_item
);
    import hcbd_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_state    r_state;
    t_state    n_state;
    t_out_item n_out_item;
    logic      advance;

    hcbd_step u_step (
        .i_state  (r_state),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_out_item)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = i_rst_n && (!r_in_valid || advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state.phase))
        else $error("phase register not one-hot");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_item.payload_valid |-> r_out_item.payload_byte == '0)
        else $error("payload byte nonzero on a non-payload item");

    a_last_is_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.chunk_last |-> r_out_item.payload_valid)
        else $error("chunk_last without payload");

    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (n_out_item.body_done || n_out_item.framing_error)
        |=> r_state.phase == PH_STOP)
        else $error("decoder not stopped after end or error");

    a_stall_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("state changed without an item");

endmodule

// ===== verif/tb_http_chunked_body_decoder.sv =====
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder;

    import hcbd_pkg::*;

    localparam int SIZE_LIMIT = (1 << SIZE_W) - 1;

    class chunk_decode_scoreboard;
        t_phase            phase;
        logic [LINE_W-1:0] line_chars;
        logic [SIZE_W-1:0] size_accum;
        logic              digits_stopped;
        logic [SIZE_W-1:0] bytes_left;
        logic              skip_left;
        t_out_item         expected_out[$];
        int unsigned       errors;

        function new();
            restart();
            errors = 0;
        endfunction

        function void start_line();
            phase          = PH_LINE;
            line_chars     = '0;
            size_accum     = '0;
            digits_stopped = 1'b0;
        endfunction

        function void restart();
            start_line();
            bytes_left = '0;
            skip_left  = 1'b0;
        endfunction

        function int hex_digit(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
            if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
            if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
            return -1;
        endfunction

        // work out the result of one accepted item and queue it
        function void note_byte(t_in_item it);
            t_out_item  r;
            logic [7:0] b;
            int         h;
            r = '0;
            b = it.in_byte;
            if (it.begin_body) restart();
            case (phase)
                PH_LINE: begin
                    if (b == CHAR_CR) begin
                        phase = PH_BREAK;
                    end else begin
                        if (line_chars < MAX_LINE_CHARS) line_chars++;
                        if (!digits_stopped) begin
                            h = hex_digit(b);
                            if (h < 0) begin
                                digits_stopped = 1'b1;
                            end else if (int'(size_accum) > ((SIZE_LIMIT - h) >>> 4)) begin
                                size_accum = '1;
                            end else begin
                                size_accum = {size_accum[SIZE_W-5:0], 4'(h)};
                            end
                        end
                    end
                end
                PH_BREAK: begin
                    if (b != CHAR_LF) r.bad_line_break = 1'b1;
                    if (line_chars == 0 || line_chars >= MAX_LINE_CHARS) begin
                        r.framing_error = 1'b1;
                        phase = PH_STOP;
                    end else if (size_accum != 0) begin
                        bytes_left = size_accum;
                        phase = PH_PAYLOAD;
                    end else begin
                        skip_left = 1'b1;
                        phase = PH_FINAL;
                    end
                end
                PH_PAYLOAD: begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    if (bytes_left <= 1) begin
                        bytes_left  = '0;
                        r.chunk_last = 1'b1;
                        skip_left   = 1'b1;
                        phase       = PH_SKIP;
                    end else begin
                        bytes_left--;
                    end
                end
                PH_SKIP: begin
                    if (skip_left) skip_left = 1'b0;
                    else start_line();
                end
                PH_FINAL: begin
                    if (skip_left) begin
                        skip_left = 1'b0;
                    end else begin
                        r.body_done = 1'b1;
                        phase = PH_STOP;
                    end
                end
                default: phase = PH_STOP;
            endcase
            expected_out.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
            if (got_v !== want_v) begin
                $error("%s: expected %0h, got %0h", name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_out.size() == 0) begin
                $error("result %h with none expected", got);
                errors++;
                return;
            end
            want = expected_out.pop_front();
            compare_field("payload_valid", want.payload_valid, got.payload_valid);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("chunk_last", want.chunk_last, got.chunk_last);
            compare_field("body_done", want.body_done, got.body_done);
            compare_field("framing_error", want.framing_error, got.framing_error);
            compare_field("bad_line_break", want.bad_line_break, got.bad_line_break);
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    chunk_decode_scoreboard decode_board;
    int          in_gap;
    bit          send_steady;
    bit          recv_steady;
    bit          begin_next;
    int unsigned bytes_sent;
    int          body_no;
    int          pick;

    http_chunked_body_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) decode_board.note_byte(i_in_item);
            if (o_out_valid && i_out_ready) decode_board.check_result(o_out_item);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic bb);
        repeat (in_gap) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= '{in_byte: b, begin_body: bb};
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
        if ($urandom_range(0, 15) == 0) send_steady = !send_steady;
        in_gap = send_steady ? 0 : $urandom_range(0, 9);
        if (in_gap != 0) i_in_valid <= 1'b0;
    endtask

    // begin_body goes on the first byte of each body
    task automatic feed_byte(input logic [7:0] b);
        send_byte(b, begin_next);
        begin_next = 1'b0;
    endtask

    task automatic drain_input();
        if (in_gap == 0) begin
            i_in_valid <= 1'b0;
            in_gap = 1;
        end
        do @(posedge i_clk); while (decode_board.expected_out.size() != 0);
    endtask

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return 8'(8'h30 + v);
        return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
    endfunction

    task automatic send_line_break();
        feed_byte(CHAR_CR);
        feed_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CHAR_LF);
    endtask

    task automatic send_skip_pair();
        if ($urandom_range(0, 9) == 0) begin
            feed_byte(8'($urandom_range(0, 255)));
            feed_byte(8'($urandom_range(0, 255)));
        end else begin
            feed_byte(CHAR_CR);
            feed_byte(CHAR_LF);
        end
    endtask

    task automatic send_size_line(input int unsigned value, input int zeros, input bit ext);
        int nd;
        nd = 1;
        while (nd < 7 && (value >> (4 * nd)) != 0) nd++;
        repeat (zeros) feed_byte(8'h30);
        for (int i = nd - 1; i >= 0; i--) feed_byte(hex_char((value >> (4 * i)) & 15));
        if (ext) begin
            feed_byte(8'h3B);
            feed_byte(hex_char($urandom_range(0, 15)));
        end
        send_line_break();
    endtask

    task automatic send_body();
        int          chunks;
        int unsigned len;
        chunks = $urandom_range(1, 4);
        begin_next = 1'b1;
        repeat (chunks) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            send_size_line(len, $urandom_range(0, 2), $urandom_range(0, 3) == 0);
            repeat (len) feed_byte(8'($urandom_range(0, 255)));
            send_skip_pair();
        end
        if ($urandom_range(0, 4) == 0) begin
            // line without a leading digit: size zero
            feed_byte(8'(8'h67 + $urandom_range(0, 19)));
            feed_byte(hex_char($urandom_range(0, 15)));
            send_line_break();
        end else begin
            send_size_line(0, $urandom_range(0, 2), $urandom_range(0, 3) == 0);
        end
        send_skip_pair();
        repeat ($urandom_range(0, 2)) feed_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_cut_chunk();
        begin_next = 1'b1;
        send_size_line($urandom_range(0, 1) ? SIZE_LIMIT : $urandom_range(SIZE_LIMIT, 'h1000000),
                       0, 1'b0);
        repeat ($urandom_range(1, 20)) feed_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(4, 12)) begin
            begin_next = ($urandom_range(0, 7) == 0);
            feed_byte(($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? CHAR_CR : CHAR_LF)
                                                  : 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_long_line();
        begin_next = 1'b1;
        repeat ($urandom_range(MAX_LINE_CHARS, MAX_LINE_CHARS + 4))
            feed_byte(hex_char($urandom_range(0, 15)));
        send_line_break();
        feed_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_empty_line();
        begin_next = 1'b1;
        send_line_break();
        feed_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin
        decode_board = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_ready = 1'b0;
        in_gap      = 0;
        send_steady = 1'b0;
        begin_next  = 1'b0;
        bytes_sent  = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty size line with a bad line break
        send_byte(CHAR_CR, 1'b0);
        send_byte(8'h78, 1'b0);
        // one-byte chunk
        send_byte(8'h31, 1'b1);
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_LF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_LF, 1'b0);
        // restart mid-chunk
        send_byte(8'h41, 1'b0);
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_LF, 1'b0);
        send_byte(8'h00, 1'b0);
        // no leading digit ends the body, then ignored byte
        send_byte(8'h3B, 1'b1);
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_CR, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        // line at the length limit
        send_byte(8'h46, 1'b1);
        repeat (MAX_LINE_CHARS - 1) send_byte(8'h66, 1'b0);
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_LF, 1'b0);

        body_no = 0;
        while (bytes_sent < 500) begin
            body_no++;
            if (body_no == 15) drain_input();
            pick = $urandom_range(0, 19);
            if (pick < 13) send_body();
            else if (pick < 15) send_cut_chunk();
            else if (pick < 17) send_noise();
            else if (pick == 17) send_long_line();
            else send_empty_line();
        end

        drain_input();
        repeat (8) @(posedge i_clk);
        if (decode_board.errors == 0) begin
            $display("tb_http_chunked_body_decoder: done, clean");
        end else begin
            $display("tb_http_chunked_body_decoder: done, errors");
        end
        $finish;
    end

    initial begin
        int stall;
        int taken;
        bit held;
        taken = 0;
        held  = 1'b0;
        recv_steady = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            // long hold-off so the block backs up into its input
            if (!held && taken >= 200) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (60) @(posedge i_clk);
            end
            if ($urandom_range(0, 15) == 0) recv_steady = !recv_steady;
            stall = recv_steady ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
        end
    end

    initial begin
        #5_000_000;
        $display("tb_http_chunked_body_decoder: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/hcbd_pkg.sv
hw/rtl/hcbd_step.sv
hw/rtl/http_chunked_body_decoder.sv
verif/tb_http_chunked_body_decoder.sv
